@@ rtl/sact_pkg.sv @@
// shared constants and types for the set-associative cache tag controller
// no dependencies
`timescale 1ns / 1ps

package sact_pkg;

    localparam int DEF_SETS       = 64;
    localparam int DEF_WAYS       = 8;
    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_ADDR_BITS  = 32;
    localparam int DEF_STAMP_BITS = 32;

    localparam int WAY_IDX_W = 4;

    localparam logic [1:0] RK_LRU  = 2'd0;
    localparam logic [1:0] RK_PLRU = 2'd1;
    localparam logic [1:0] RK_TREE = 2'd2;
    localparam logic [1:0] RK_RAND = 2'd3;

    localparam logic [1:0] OP_STATUS = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_WBACK  = 2'd2;
    localparam logic [1:0] OP_STORE  = 2'd3;

    localparam logic [2:0] CFG_REPL     = 3'd0;
    localparam logic [2:0] CFG_WALLOC   = 3'd1;
    localparam logic [2:0] CFG_WBACK    = 3'd2;
    localparam logic [2:0] CFG_PF_EN    = 3'd3;
    localparam logic [2:0] CFG_PF_CNT   = 3'd4;
    localparam logic [2:0] CFG_PF_STRD  = 3'd5;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [3:0]  PF_MAX    = 4'd8;

    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic [WAY_IDX_W-1:0] victim;
    } sel_t;

endpackage

@@ rtl/sact_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sact_way_sel.sv @@
// hit detection and replacement victim choice over one set row
// depends on sact_pkg
`timescale 1ns / 1ps

module sact_way_sel #(
    parameter int WAYS  = sact_pkg::DEF_WAYS,
    parameter int TAG_W = 20,
    parameter int SW    = sact_pkg::DEF_STAMP_BITS,
    parameter int WAY_W = 3
) (
    input  logic [WAYS*TAG_W-1:0] tags,
    input  logic [WAYS*SW-1:0]    stamps,
    input  logic [WAYS-1:0]       valid,
    input  logic [WAYS-1:0]       mru,
    input  logic [TAG_W-1:0]      tag,
    input  logic [1:0]            kind,
    input  logic [WAY_W-1:0]      rand_way,
    output sact_pkg::sel_t        sel
);

    localparam int P = 1 << WAY_W;

    logic [WAY_W-1:0] hit_w;
    logic             hit_f;
    logic [WAY_W-1:0] inv_w;
    logic             inv_f;
    logic [WAY_W-1:0] plru_w;
    logic [WAY_W-1:0] node_idx [2*P];
    logic [SW-1:0]    node_stm [2*P];
    logic             node_ok  [2*P];
    logic [WAY_W-1:0] vic;

    always_comb
    begin
        hit_w  = '0;
        hit_f  = 1'b0;
        inv_w  = '0;
        inv_f  = 1'b0;
        plru_w = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && tags[w*TAG_W +: TAG_W] == tag)
            begin
                hit_w = WAY_W'(w);
                hit_f = 1'b1;
            end
            if (!valid[w])
            begin
                inv_w = WAY_W'(w);
                inv_f = 1'b1;
            end
            if (!mru[w])
            begin
                plru_w = WAY_W'(w);
            end
        end
    end

    // min-stamp tree, lower way wins a tie
    always_comb
    begin
        for (int n = 0; n < 2 * P; n++)
        begin
            node_idx[n] = '0;
            node_stm[n] = '0;
            node_ok[n]  = 1'b0;
        end
        for (int i = 0; i < P; i++)
        begin
            node_idx[P+i] = WAY_W'(i);
            if (i < WAYS)
            begin
                node_stm[P+i] = stamps[i*SW +: SW];
                node_ok[P+i]  = 1'b1;
            end
        end
        for (int n = P - 1; n >= 1; n--)
        begin
            if (node_ok[2*n+1] && (!node_ok[2*n] || node_stm[2*n+1] < node_stm[2*n]))
            begin
                node_idx[n] = node_idx[2*n+1];
                node_stm[n] = node_stm[2*n+1];
            end
            else
            begin
                node_idx[n] = node_idx[2*n];
                node_stm[n] = node_stm[2*n];
            end
            node_ok[n] = node_ok[2*n] || node_ok[2*n+1];
        end
    end

    always_comb
    begin
        case (kind)
            sact_pkg::RK_PLRU: vic = plru_w;
            sact_pkg::RK_RAND: vic = (WAYS > 1) ? rand_way : '0;
            default:           vic = inv_f ? inv_w : node_idx[1];
        endcase
    end

    assign sel.hit     = hit_f;
    assign sel.hit_way = sact_pkg::WAY_IDX_W'(hit_w);
    assign sel.victim  = sact_pkg::WAY_IDX_W'(vic);

endmodule

@@ rtl/set_assoc_cache_tag_controller.sv @@
// top level: access sequencer around one set-row metadata ram
// an access is handled by row read, victim select and write-back of the row, then its items
// go one at a time through the output holding register; each prefetched line repeats
// the read, select and write-back of the row and sends its results the same way
// reset: async active low; then a clearing pass zeroes every row,
// no item is accepted during it
// depends on sact_pkg, sact_ram, sact_way_sel
`timescale 1ns / 1ps

module set_assoc_cache_tag_controller #(
    parameter int SETS       = sact_pkg::DEF_SETS,
    parameter int WAYS       = sact_pkg::DEF_WAYS,
    parameter int LINE_BYTES = sact_pkg::DEF_LINE_BYTES,
    parameter int ADDR_BITS  = sact_pkg::DEF_ADDR_BITS,
    parameter int STAMP_BITS = sact_pkg::DEF_STAMP_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  op_kind,
    output logic [31:0] mem_address,
    output logic        hit,
    output logic [2:0]  way,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int SET_IW = SET_W > 0 ? SET_W : 1;
    localparam int AW     = ADDR_BITS < 32 ? ADDR_BITS : 32;
    localparam int TAG_W  = AW - OFF_W - SET_W;
    localparam int SW     = STAMP_BITS;
    localparam int WAY_W  = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam logic [31:0] AMASK = ADDR_BITS >= 32 ? 32'hFFFF_FFFF
                                                    : 32'((64'd1 << AW) - 64'd1);
    localparam logic [31:0] LMASK = ~32'(LINE_BYTES - 1);
    localparam int STM_OFF = WAYS * TAG_W;
    localparam int DRT_OFF = STM_OFF + WAYS * SW;
    localparam int VLD_OFF = DRT_OFF + WAYS;
    localparam int MRU_OFF = VLD_OFF + WAYS;
    localparam int ROW_W   = MRU_OFF + WAYS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_UPD, S_EMIT, S_NEXT, S_FINAL
    } state_t;

    state_t state_reg;

    logic [1:0]  rk_reg;
    logic        walloc_reg;
    logic        wback_reg;
    logic        pf_en_reg;
    logic [3:0]  pf_cnt_reg;
    logic [7:0]  pf_strd_reg;

    logic [31:0] count_reg;
    logic [15:0] lfsr_reg;
    logic [SET_IW-1:0] clr_reg;
    logic        rd_reg;
    logic        pf_reg;
    logic [3:0]  pf_left_reg;
    logic [31:0] line_reg;
    logic [ROW_W-1:0] wrow_reg;
    logic        row_we_reg;

    logic        f_st_reg, f_wb_reg, f_fi_reg, f_so_reg;
    logic        st_hit_reg;
    logic [WAY_W-1:0] st_way_reg, fi_way_reg, so_way_reg;
    logic [31:0] wb_addr_reg;

    logic        hold_valid_reg;
    logic [1:0]  hold_kind_reg;
    logic [31:0] hold_addr_reg;
    logic        hold_hit_reg;
    logic [2:0]  hold_way_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_addr_reg;
    logic        out_hit_reg;
    logic [2:0]  out_way_reg;
    logic        out_last_reg;

    logic [31:0] in_line;
    logic [31:0] pa_next;
    logic [31:0] step;
    logic [SET_IW-1:0] in_set, pa_set, cur_set;
    logic [TAG_W-1:0]  cur_tag;
    logic [ROW_W-1:0]  rrow, new_row;
    logic        ram_we;
    logic [SET_IW-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [15:0] lfsr_next;
    sact_pkg::sel_t sel;

    logic        s_hit, no_alloc, alloc, touch_en;
    logic [WAY_W-1:0] hw, vw, tw;
    logic [WAYS-1:0]  mru_new;
    logic [TAG_W-1:0] vtag;
    logic        can_push;
    logic        push;
    logic [1:0]  n_kind;
    logic [31:0] n_addr;
    logic        n_hit;
    logic [WAY_W-1:0] n_way;
    logic [3:0]  pf_cnt_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    assign in_line = address & AMASK & LMASK;
    assign step    = {{24{pf_strd_reg[7]}}, pf_strd_reg} << OFF_W;
    assign pa_next = (line_reg + step) & AMASK & LMASK;

    assign in_set  = (SETS > 1) ? in_line[OFF_W +: SET_IW] : '0;
    assign pa_set  = (SETS > 1) ? pa_next[OFF_W +: SET_IW] : '0;
    assign cur_set = (SETS > 1) ? line_reg[OFF_W +: SET_IW] : '0;
    assign cur_tag = line_reg[OFF_W + SET_W +: TAG_W];

    assign lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};
    assign pf_cnt_sat = (pf_cnt_reg > sact_pkg::PF_MAX) ? sact_pkg::PF_MAX : pf_cnt_reg;

    sact_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rrow)
    );

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_UPD && row_we_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : cur_set;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : wrow_reg;
    assign ram_raddr = (state_reg == S_IDLE) ? in_set : pa_set;

    sact_way_sel #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .SW    (SW),
        .WAY_W (WAY_W)
    ) u_way_sel (
        .tags     (rrow[0 +: WAYS*TAG_W]),
        .stamps   (rrow[STM_OFF +: WAYS*SW]),
        .valid    (rrow[VLD_OFF +: WAYS]),
        .mru      (rrow[MRU_OFF +: WAYS]),
        .tag      (cur_tag),
        .kind     (rk_reg),
        .rand_way (lfsr_next[WAY_W-1:0]),
        .sel      (sel)
    );

    // row update for the line in flight
    always_comb
    begin
        s_hit    = sel.hit;
        hw       = sel.hit_way[WAY_W-1:0];
        vw       = sel.victim[WAY_W-1:0];
        no_alloc = !pf_reg && !rd_reg && !walloc_reg && !s_hit;
        alloc    = !s_hit && !no_alloc;
        tw       = s_hit ? hw : vw;
        touch_en = (s_hit && !pf_reg) || alloc;
        vtag     = rrow[vw*TAG_W +: TAG_W];
        new_row  = rrow;
        mru_new  = rrow[MRU_OFF +: WAYS];
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == tw)
            begin
                mru_new[w] = 1'b1;
            end
        end
        if (&mru_new)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                mru_new[w] = (WAY_W'(w) == tw);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == tw && touch_en)
            begin
                new_row[STM_OFF + w*SW +: SW] = SW'(count_reg);
                if (alloc)
                begin
                    new_row[w*TAG_W +: TAG_W] = cur_tag;
                    new_row[VLD_OFF + w]      = 1'b1;
                    new_row[DRT_OFF + w]      = 1'b0;
                end
                if (!pf_reg && !rd_reg && wback_reg)
                begin
                    new_row[DRT_OFF + w] = 1'b1;
                end
            end
        end
        if (touch_en)
        begin
            new_row[MRU_OFF +: WAYS] = mru_new;
        end
    end

    // next item to send, in status, writeback, fill, store order
    always_comb
    begin
        can_push = !out_valid_reg || !out_stall;
        push     = (state_reg == S_EMIT) && can_push &&
                   (f_st_reg || f_wb_reg || f_fi_reg || f_so_reg);
        n_kind   = sact_pkg::OP_STORE;
        n_addr   = line_reg;
        n_hit    = 1'b0;
        n_way    = so_way_reg;
        if (f_st_reg)
        begin
            n_kind = sact_pkg::OP_STATUS;
            n_hit  = st_hit_reg;
            n_way  = st_way_reg;
        end
        else if (f_wb_reg)
        begin
            n_kind = sact_pkg::OP_WBACK;
            n_addr = wb_addr_reg;
            n_way  = fi_way_reg;
        end
        else if (f_fi_reg)
        begin
            n_kind = sact_pkg::OP_FILL;
            n_way  = fi_way_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            rk_reg         <= sact_pkg::RK_LRU;
            walloc_reg     <= 1'b1;
            wback_reg      <= 1'b1;
            pf_en_reg      <= 1'b0;
            pf_cnt_reg     <= '0;
            pf_strd_reg    <= '0;
            count_reg      <= '0;
            lfsr_reg       <= sact_pkg::LFSR_SEED;
            clr_reg        <= '0;
            pf_left_reg    <= '0;
            row_we_reg     <= 1'b0;
            f_st_reg       <= 1'b0;
            f_wb_reg       <= 1'b0;
            f_fi_reg       <= 1'b0;
            f_so_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    sact_pkg::CFG_REPL:    rk_reg      <= cfg_data[1:0];
                    sact_pkg::CFG_WALLOC:  walloc_reg  <= cfg_data[0];
                    sact_pkg::CFG_WBACK:   wback_reg   <= cfg_data[0];
                    sact_pkg::CFG_PF_EN:   pf_en_reg   <= cfg_data[0];
                    sact_pkg::CFG_PF_CNT:  pf_cnt_reg  <= cfg_data[3:0];
                    sact_pkg::CFG_PF_STRD: pf_strd_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall && !(push && hold_valid_reg) &&
                state_reg != S_FINAL)
            begin
                out_valid_reg <= 1'b0;
            end

            if (push)
            begin
                if (hold_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= hold_kind_reg;
                    out_addr_reg  <= hold_addr_reg;
                    out_hit_reg   <= hold_hit_reg;
                    out_way_reg   <= hold_way_reg;
                    out_last_reg  <= 1'b0;
                end
                hold_valid_reg <= 1'b1;
                hold_kind_reg  <= n_kind;
                hold_addr_reg  <= n_addr;
                hold_hit_reg   <= n_hit;
                hold_way_reg   <= 3'(n_way);
                if (f_st_reg)
                begin
                    f_st_reg <= 1'b0;
                end
                else if (f_wb_reg)
                begin
                    f_wb_reg <= 1'b0;
                end
                else if (f_fi_reg)
                begin
                    f_fi_reg <= 1'b0;
                end
                else
                begin
                    f_so_reg <= 1'b0;
                end
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SET_IW'(SETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rd_reg    <= req_type;
                        pf_reg    <= 1'b0;
                        line_reg  <= in_line;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    wrow_reg    <= new_row;
                    row_we_reg  <= touch_en;
                    f_st_reg    <= !pf_reg;
                    f_wb_reg    <= alloc && rrow[VLD_OFF + vw] && rrow[DRT_OFF + vw];
                    f_fi_reg    <= alloc;
                    f_so_reg    <= !pf_reg && !rd_reg && (no_alloc || !wback_reg);
                    st_hit_reg  <= s_hit;
                    st_way_reg  <= s_hit ? hw : (alloc ? vw : '0);
                    fi_way_reg  <= vw;
                    so_way_reg  <= no_alloc ? '0 : tw;
                    wb_addr_reg <= (32'(vtag) << (OFF_W + SET_W)) |
                                   (32'(cur_set) << OFF_W);
                    if (alloc && rk_reg == sact_pkg::RK_RAND)
                    begin
                        lfsr_reg <= lfsr_next;
                    end
                    if (!pf_reg)
                    begin
                        pf_left_reg <= (alloc && pf_en_reg && pf_cnt_sat > 4'd1)
                                       ? pf_cnt_sat - 4'd1 : 4'd0;
                    end
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!(f_st_reg || f_wb_reg || f_fi_reg || f_so_reg))
                    begin
                        state_reg <= (pf_left_reg != '0) ? S_NEXT : S_FINAL;
                    end
                end
                S_NEXT:
                begin
                    line_reg    <= pa_next;
                    pf_reg      <= 1'b1;
                    pf_left_reg <= pf_left_reg - 4'd1;
                    state_reg   <= S_LOOK;
                end
                S_FINAL:
                begin
                    if (can_push)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= hold_kind_reg;
                        out_addr_reg   <= hold_addr_reg;
                        out_hit_reg    <= hold_hit_reg;
                        out_way_reg    <= hold_way_reg;
                        out_last_reg   <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign op_kind     = out_kind_reg;
    assign mem_address = out_addr_reg;
    assign hit         = out_hit_reg;
    assign way         = out_way_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held item left over at idle");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_LOOK))
        else $error("accepted item did not start a lookup");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("row write while idle");
`endif

endmodule
